### rtl/core/cca_pkg.sv
// Shared types and constants for the cave cellular automaton.
// No dependencies; used by every module of the block except cca_ram.
package cca_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	localparam int ROW_W  = $clog2(MAX_ROWS);      // grid row address
	localparam int COL_W  = $clog2(MAX_COLS);      // grid column index
	localparam int RDIM_W = $clog2(MAX_ROWS + 1);  // rows in use, 1..MAX_ROWS
	localparam int CDIM_W = $clog2(MAX_COLS + 1);  // columns in use
	localparam int CNT_W  = $clog2(MAX_ROWS + 2);  // sweep step, 0..MAX_ROWS+1

	// input field widths
	localparam int MODE_W = 2;
	localparam int ADR_W  = 6;

	// register file
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_CNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALL_THR  = 2'd3;

	// request modes
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	typedef enum logic [1:0] {
		K_NOP,
		K_LOAD,
		K_RUN,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADR_W-1:0]  row;
		logic [ADR_W-1:0]  col;
		logic              wall;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD_WAIT,
		ST_READ_WAIT,
		ST_RUN
	} state_t;

endpackage

### rtl/core/cca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/cca_front.sv
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on cca_pkg.
module cca_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cca_pkg::MODE_W-1:0] mode,
	input  logic [cca_pkg::ADR_W-1:0]  row,
	input  logic [cca_pkg::ADR_W-1:0]  col,
	input  logic                       wall_in,
	output logic                       q_valid,
	output cca_pkg::cmd_t              q_cmd,
	input  logic                       q_pop
);

	cca_pkg::cmd_t fifo_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    count_q;
	cca_pkg::cmd_t cmd_new;
	logic          in_range;
	logic          push;

	// addresses beyond the store make loads and reads no-ops
	assign in_range = (32'(row) < cca_pkg::MAX_ROWS) && (32'(col) < cca_pkg::MAX_COLS);

	always_comb begin
		cmd_new.row  = row;
		cmd_new.col  = col;
		cmd_new.wall = wall_in;
		case (mode)
			cca_pkg::MODE_LOAD: cmd_new.kind = in_range ? cca_pkg::K_LOAD : cca_pkg::K_NOP;
			cca_pkg::MODE_RUN:  cmd_new.kind = cca_pkg::K_RUN;
			cca_pkg::MODE_READ: cmd_new.kind = in_range ? cca_pkg::K_READ : cca_pkg::K_NOP;
			default:            cmd_new.kind = cca_pkg::K_NOP;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

### rtl/core/cca_back.sv
// Back end: register file, ping-pong grid banks, generation sweep, result register.
// Depends on cca_pkg and cca_ram.
module cca_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [cca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           q_valid,
	input  cca_pkg::cmd_t                  q_cmd,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           wall_out,
	output logic                           run_done
);

	localparam int MR = cca_pkg::MAX_ROWS;
	localparam int MC = cca_pkg::MAX_COLS;

	cca_pkg::state_t st_q, st_d;
	cca_pkg::cmd_t   cmd_q;

	logic [6:0] rows_q, cols_q;
	logic [7:0] iter_q, gen_q;
	logic [3:0] thr_q;

	logic [cca_pkg::RDIM_W-1:0] rows_eff;
	logic [cca_pkg::CDIM_W-1:0] cols_eff;
	logic [MC-1:0]              col_mask;

	logic [cca_pkg::CNT_W-1:0] cnt_q;
	logic [cca_pkg::CNT_W-1:0] in_idx, mid_idx;
	logic                      cur_q;
	logic [MC-1:0]             top_q, mid_q, mid_raw_q;
	logic [MC-1:0]             in_msk, new_row;
	logic                      sweep_end, gen_last;

	logic                         ram_we, ram_wbank;
	logic [cca_pkg::ROW_W-1:0]    ram_waddr, ram_raddr;
	logic [MC-1:0]                ram_wdata, rdata_a, rdata_b, rdata_sel;

	logic out_set, out_wall_d, out_done_d;
	logic out_valid_q, out_wall_q, out_done_q;
	logic [cca_pkg::COL_W-1:0] col_idx;

	// clamp the dimensions in use
	always_comb begin
		if (rows_q == 7'd0) begin
			rows_eff = cca_pkg::RDIM_W'(1);
		end else if (32'(rows_q) > MR) begin
			rows_eff = cca_pkg::RDIM_W'(MR);
		end else begin
			rows_eff = cca_pkg::RDIM_W'(rows_q);
		end
		if (cols_q == 7'd0) begin
			cols_eff = cca_pkg::CDIM_W'(1);
		end else if (32'(cols_q) > MC) begin
			cols_eff = cca_pkg::CDIM_W'(MC);
		end else begin
			cols_eff = cca_pkg::CDIM_W'(cols_q);
		end
		for (int c = 0; c < MC; c++) begin
			col_mask[c] = (32'(c) < 32'(cols_eff));
		end
	end

	cca_ram #(.WIDTH(MC), .DEPTH(MR)) u_bank_a (
		.clk  (clk),
		.we   (ram_we && !ram_wbank),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata_a)
	);

	cca_ram #(.WIDTH(MC), .DEPTH(MR)) u_bank_b (
		.clk  (clk),
		.we   (ram_we && ram_wbank),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata_b)
	);

	assign rdata_sel = cur_q ? rdata_b : rdata_a;
	assign col_idx   = cca_pkg::COL_W'(cmd_q.col);

	// sweep window: row read last cycle arrives now as the bottom row
	assign in_idx    = cnt_q - cca_pkg::CNT_W'(1);
	assign mid_idx   = cnt_q - cca_pkg::CNT_W'(2);
	assign in_msk    = (cnt_q != '0 && 32'(in_idx) < 32'(rows_eff)) ? (rdata_sel & col_mask) : '0;
	assign sweep_end = (32'(cnt_q) == MR + 1);
	assign gen_last  = (gen_q + 8'd1 == iter_q);

	always_comb begin
		logic [MC+1:0] tp, md, bt;
		logic [3:0]    n;
		logic          row_use;
		tp = {1'b0, top_q, 1'b0};
		md = {1'b0, mid_q, 1'b0};
		bt = {1'b0, in_msk, 1'b0};
		row_use = (32'(mid_idx) < 32'(rows_eff));
		for (int c = 0; c < MC; c++) begin
			n = 4'(tp[c]) + 4'(tp[c+1]) + 4'(tp[c+2]) + 4'(md[c]) + 4'(md[c+2])
			  + 4'(bt[c]) + 4'(bt[c+1]) + 4'(bt[c+2]);
			// cells outside the area in use are copied through
			new_row[c] = (row_use && col_mask[c]) ? (n > thr_q) : mid_raw_q[c];
		end
	end

	assign q_pop = (st_q == cca_pkg::ST_IDLE) && q_valid && !out_valid_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			cca_pkg::ST_IDLE: begin
				if (q_pop) begin
					case (q_cmd.kind)
						cca_pkg::K_LOAD: st_d = cca_pkg::ST_LOAD_WAIT;
						cca_pkg::K_READ: st_d = cca_pkg::ST_READ_WAIT;
						cca_pkg::K_RUN:  st_d = (iter_q == 8'd0) ? cca_pkg::ST_IDLE : cca_pkg::ST_RUN;
						default:         st_d = cca_pkg::ST_IDLE;
					endcase
				end
			end
			cca_pkg::ST_LOAD_WAIT: st_d = cca_pkg::ST_IDLE;
			cca_pkg::ST_READ_WAIT: st_d = cca_pkg::ST_IDLE;
			cca_pkg::ST_RUN: begin
				if (sweep_end && gen_last) begin
					st_d = cca_pkg::ST_IDLE;
				end
			end
			default: st_d = cca_pkg::ST_IDLE;
		endcase
	end

	// memory control and results
	always_comb begin
		ram_we     = 1'b0;
		ram_wbank  = cur_q;
		ram_waddr  = cca_pkg::ROW_W'(cmd_q.row);
		ram_wdata  = rdata_sel;
		ram_raddr  = cca_pkg::ROW_W'(q_cmd.row);
		out_set    = 1'b0;
		out_wall_d = 1'b0;
		out_done_d = 1'b0;
		case (st_q)
			cca_pkg::ST_IDLE: begin
				if (q_pop) begin
					case (q_cmd.kind)
						cca_pkg::K_NOP: out_set = 1'b1;
						cca_pkg::K_RUN: begin
							if (iter_q == 8'd0) begin
								out_set    = 1'b1;
								out_done_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			cca_pkg::ST_LOAD_WAIT: begin
				ram_we             = 1'b1;
				ram_wdata[col_idx] = cmd_q.wall;
				out_set            = 1'b1;
			end
			cca_pkg::ST_READ_WAIT: begin
				out_set    = 1'b1;
				out_wall_d = rdata_sel[col_idx];
			end
			cca_pkg::ST_RUN: begin
				ram_raddr = (32'(cnt_q) < MR) ? cca_pkg::ROW_W'(cnt_q) : '0;
				ram_wbank = ~cur_q;
				ram_waddr = cca_pkg::ROW_W'(mid_idx);
				ram_wdata = new_row;
				ram_we    = (cnt_q >= cca_pkg::CNT_W'(2));
				if (sweep_end && gen_last) begin
					out_set    = 1'b1;
					out_done_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (st_q == cca_pkg::ST_RUN) begin
			if (cnt_q == '0) begin
				mid_q <= '0;
			end else begin
				top_q     <= mid_q;
				mid_q     <= in_msk;
				mid_raw_q <= rdata_sel;
			end
		end
		if (out_set) begin
			out_wall_q <= out_wall_d;
			out_done_q <= out_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= cca_pkg::ST_IDLE;
			cnt_q       <= '0;
			gen_q       <= 8'd0;
			cur_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rows_q      <= 7'd64;
			cols_q      <= 7'd64;
			iter_q      <= 8'd5;
			thr_q       <= 4'd4;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_addr)
					cca_pkg::CFG_NUM_ROWS: rows_q <= cfg_data[6:0];
					cca_pkg::CFG_NUM_COLS: cols_q <= cfg_data[6:0];
					cca_pkg::CFG_ITER_CNT: iter_q <= cfg_data;
					cca_pkg::CFG_WALL_THR: thr_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (q_pop) begin
				cnt_q <= '0;
				gen_q <= 8'd0;
			end else if (st_q == cca_pkg::ST_RUN) begin
				if (sweep_end) begin
					cnt_q <= '0;
					gen_q <= gen_q + 8'd1;
					cur_q <= ~cur_q;
				end else begin
					cnt_q <= cnt_q + cca_pkg::CNT_W'(1);
				end
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign wall_out  = out_wall_q;
	assign run_done  = out_done_q;

endmodule

### rtl/core/cave_cellular_automaton.sv
// Top level of the cave cellular automaton: ports, field unpacking.
// Depends on cca_pkg, cca_front, cca_back (and cca_ram below it).
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      request: mode (tuser); row, col, wall_in (tdata)
// m_*       out  tvalid/tready      result: wall_out, run_done
// cfg_*     in   cfg_we             register index, write data
//
// Load and read requests go through the back end as a row read, then
// write-back or bit select. During a run, each generation sweeps every row
// of the source bank through a three-row window, one row per cycle, writing
// the other bank.
// The front queue holds two requests and keeps accepting, until it is full,
// while the back end works or a result waits. Reset clears control and
// registers only; the grid banks are not cleared.
module cave_cellular_automaton (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // row[5:0], col[11:6], wall_in[12]
	input  logic [1:0]                     s_tuser,   // mode[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // wall_out[0], run_done[1]
	input  logic                           cfg_we,
	input  logic [cca_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [cca_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic          q_valid, q_pop;
	cca_pkg::cmd_t q_cmd;
	logic          wall_out, run_done;

	cca_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.mode    (s_tuser),
		.row     (s_tdata[5:0]),
		.col     (s_tdata[11:6]),
		.wall_in (s_tdata[12]),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	cca_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.wall_out (wall_out),
		.run_done (run_done)
	);

	// bits 15:13 of s_tdata are padding
	assign m_tdata = {6'd0, run_done, wall_out};

endmodule
